[rtl/drgs_pkg.sv]
package drgs_pkg;

  localparam int DigitCount = 5;
  localparam int ColsPerDigit = 6;
  localparam int GlyphCols = 5;
  localparam int ValueWidth = 16;
  localparam int BcdWidth = 4 * DigitCount;

  localparam logic [2:0] LastPos = 3'd4;
  localparam logic [2:0] LastCol = 3'd5;
  localparam logic [3:0] LastShift = 4'd15;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONVERT,
    FE_PUSH
  } drgs_front_state_t;

  // One classified readout, position 0 is the most significant digit.
  typedef struct packed {
    logic [DigitCount-1:0][3:0] digits;
    logic [DigitCount-1:0]      blank;
    logic [2:0]                 highlight;
    logic [2:0]                 shown;
  } drgs_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } drgs_queue_status_t;

  // 5x8 digit font, bit 0 is the top pixel.
  function automatic logic [7:0] drgs_glyph(input logic [3:0] digit, input logic [2:0] col);
    logic [7:0] bits;
    bits = 8'h00;
    case ({digit, col})
      {4'd0, 3'd0}: bits = 8'h7C;
      {4'd0, 3'd1}: bits = 8'hA2;
      {4'd0, 3'd2}: bits = 8'h92;
      {4'd0, 3'd3}: bits = 8'h8A;
      {4'd0, 3'd4}: bits = 8'h7C;
      {4'd1, 3'd1}: bits = 8'h84;
      {4'd1, 3'd2}: bits = 8'hFE;
      {4'd1, 3'd3}: bits = 8'h80;
      {4'd2, 3'd0}: bits = 8'hE4;
      {4'd2, 3'd1}: bits = 8'h92;
      {4'd2, 3'd2}: bits = 8'h92;
      {4'd2, 3'd3}: bits = 8'h92;
      {4'd2, 3'd4}: bits = 8'h8C;
      {4'd3, 3'd0}: bits = 8'h44;
      {4'd3, 3'd1}: bits = 8'h82;
      {4'd3, 3'd2}: bits = 8'h92;
      {4'd3, 3'd3}: bits = 8'h92;
      {4'd3, 3'd4}: bits = 8'h6C;
      {4'd4, 3'd0}: bits = 8'h30;
      {4'd4, 3'd1}: bits = 8'h28;
      {4'd4, 3'd2}: bits = 8'h24;
      {4'd4, 3'd3}: bits = 8'hFE;
      {4'd4, 3'd4}: bits = 8'h20;
      {4'd5, 3'd0}: bits = 8'h4E;
      {4'd5, 3'd1}: bits = 8'h8A;
      {4'd5, 3'd2}: bits = 8'h8A;
      {4'd5, 3'd3}: bits = 8'h8A;
      {4'd5, 3'd4}: bits = 8'h72;
      {4'd6, 3'd0}: bits = 8'h78;
      {4'd6, 3'd1}: bits = 8'h94;
      {4'd6, 3'd2}: bits = 8'h92;
      {4'd6, 3'd3}: bits = 8'h92;
      {4'd6, 3'd4}: bits = 8'h60;
      {4'd7, 3'd0}: bits = 8'h02;
      {4'd7, 3'd1}: bits = 8'hE2;
      {4'd7, 3'd2}: bits = 8'h12;
      {4'd7, 3'd3}: bits = 8'h0A;
      {4'd7, 3'd4}: bits = 8'h06;
      {4'd8, 3'd0}: bits = 8'h6C;
      {4'd8, 3'd1}: bits = 8'h92;
      {4'd8, 3'd2}: bits = 8'h92;
      {4'd8, 3'd3}: bits = 8'h92;
      {4'd8, 3'd4}: bits = 8'h6C;
      {4'd9, 3'd0}: bits = 8'h0C;
      {4'd9, 3'd1}: bits = 8'h92;
      {4'd9, 3'd2}: bits = 8'h92;
      {4'd9, 3'd3}: bits = 8'h52;
      {4'd9, 3'd4}: bits = 8'h3C;
      default: bits = 8'h00;
    endcase
    return bits;
  endfunction

endpackage

[rtl/decimal_readout_glyph_stream.sv]
// Decimal readout as a stream of display columns.
//
// Pulse start with value and highlight_position while busy is low; the
// transaction is taken at that edge. The value is shown as five decimal
// digits with leading zeros blanked (the last digit always shows), each
// digit as five font columns and one spacer, thirty columns in all. The
// highlighted position is inverted; 5 to 7 highlight nothing.
//
// Each column is on column_bits for one cycle with strobe high; the last
// one carries last_column and digits_shown. The receiver cannot stall.
//
// The front converts one bit per cycle through a double dabble shifter
// and hands the entry to a two-entry queue; busy stays high after a
// transaction until the entry is pushed, which waits while the queue is full.
// The first column is registered out of the back end after the entry is
// popped from the queue. Sustained throughput is set by the back end
// emitting one column per cycle; back-to-back readouts stream with no gap.
//
// Reset clears the front state, the queue and the back end; no strobe
// follows until a new transaction.
module decimal_readout_glyph_stream import drgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] value,
  input  logic [2:0]            highlight_position,
  output logic                  strobe,
  output logic [7:0]            column_bits,
  output logic                  last_column,
  output logic [2:0]            digits_shown
);

  drgs_entry_t        push_data;
  drgs_entry_t        pop_data;
  drgs_queue_status_t queue_status;
  logic               push;
  logic               pop;

  drgs_front u_front (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .value              (value),
    .highlight_position (highlight_position),
    .queue_full         (queue_status.full),
    .push               (push),
    .push_data          (push_data)
  );

  drgs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (queue_status)
  );

  drgs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_status.empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .strobe       (strobe),
    .column_bits  (column_bits),
    .last_column  (last_column),
    .digits_shown (digits_shown)
  );

endmodule

[rtl/drgs_front.sv]
module drgs_front import drgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] value,
  input  logic [2:0]            highlight_position,
  input  logic                  queue_full,
  output logic                  push,
  output drgs_entry_t           push_data
);

  drgs_front_state_t state, state_next;

  logic [ValueWidth-1:0] bin;
  logic [BcdWidth-1:0]   bcd;
  logic [BcdWidth-1:0]   bcd_adj;
  logic [3:0]            shift_count;
  logic [2:0]            highlight;
  logic                  accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy = 1'b1;
    push = 1'b0;
    case (state)
      FE_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = FE_CONVERT;
        end
      end
      FE_CONVERT: begin
        if (shift_count == LastShift) begin
          state_next = FE_PUSH;
        end
      end
      FE_PUSH: begin
        // hold the finished entry until the queue has room
        if (!queue_full) begin
          push = 1'b1;
          state_next = FE_IDLE;
        end
      end
      default: begin
        state_next = FE_IDLE;
      end
    endcase
  end

  // Double dabble: add 3 to every digit of 5 or more, then shift in one bit.
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < DigitCount; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin <= value;
      bcd <= '0;
      highlight <= highlight_position;
      shift_count <= '0;
    end else if (state == FE_CONVERT) begin
      bin <= {bin[ValueWidth-2:0], 1'b0};
      bcd <= {bcd_adj[BcdWidth-2:0], bin[ValueWidth-1]};
      shift_count <= shift_count + 4'd1;
    end
  end

  // Classify: blank leading zeros, never the last position.
  always_comb begin
    logic leading;
    logic [2:0] shown;
    leading = 1'b1;
    shown = '0;
    push_data.blank = '0;
    for (int i = 0; i < DigitCount; i++) begin
      push_data.digits[i] = bcd[4*(DigitCount-1-i) +: 4];
      if (leading && (i != DigitCount - 1) && (push_data.digits[i] == 4'd0)) begin
        push_data.blank[i] = 1'b1;
      end else begin
        leading = 1'b0;
        shown = shown + 3'd1;
      end
    end
    push_data.highlight = highlight;
    push_data.shown = shown;
  end

endmodule

[rtl/drgs_queue.sv]
module drgs_queue import drgs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  drgs_entry_t        push_data,
  input  logic               pop,
  output drgs_entry_t        pop_data,
  output drgs_queue_status_t status
);

  drgs_entry_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/drgs_back.sv]
module drgs_back import drgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        queue_empty,
  input  drgs_entry_t pop_data,
  output logic        pop,
  output logic        strobe,
  output logic [7:0]  column_bits,
  output logic        last_column,
  output logic [2:0]  digits_shown
);

  drgs_entry_t cur;
  logic        active;
  logic [2:0]  pos;
  logic [2:0]  col;
  logic        at_end;
  logic [3:0]  digit;
  logic [7:0]  glyph_bits;
  logic [7:0]  mask;

  assign at_end = (pos == LastPos) && (col == LastCol);
  // take the next readout with no gap after the last column
  assign pop = !queue_empty && (!active || at_end);

  always_comb begin
    digit = cur.digits[pos];
    glyph_bits = 8'h00;
    if (!cur.blank[pos]) begin
      glyph_bits = drgs_glyph(digit, col);
    end
    mask = (cur.highlight == pos) ? 8'hFF : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (at_end) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
      pos <= '0;
      col <= '0;
    end else if (active) begin
      if (col == LastCol) begin
        col <= '0;
        pos <= pos + 3'd1;
      end else begin
        col <= col + 3'd1;
      end
    end
    column_bits  <= glyph_bits ^ mask;
    last_column  <= at_end;
    digits_shown <= at_end ? cur.shown : 3'd0;
  end

endmodule

[verif/readout_checker.sv]
`timescale 1ns / 1ps

module readout_checker import drgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [ValueWidth-1:0] value,
  input  logic [2:0]            highlight_position,
  input  logic                  strobe,
  input  logic [7:0]            column_bits,
  input  logic                  last_column,
  input  logic [2:0]            digits_shown,
  output int                    error_count,
  output int                    pending_count,
  output int                    checked_count
);

  typedef struct packed {
    logic [7:0] bits;
    logic       last;
    logic [2:0] shown;
  } column_t;

  column_t expected_columns[$];

  initial begin
    error_count   = 0;
    pending_count = 0;
    checked_count = 0;
  end

  // Five font columns of one digit, leftmost column in the top byte.
  function automatic logic [7:0] font_column(input logic [3:0] digit, input int col);
    logic [39:0] row;
    case (digit)
      4'd0: row = 40'h7CA2928A7C;
      4'd1: row = 40'h0084FE8000;
      4'd2: row = 40'hE49292928C;
      4'd3: row = 40'h448292926C;
      4'd4: row = 40'h302824FE20;
      4'd5: row = 40'h4E8A8A8A72;
      4'd6: row = 40'h7894929260;
      4'd7: row = 40'h02E2120A06;
      4'd8: row = 40'h6C9292926C;
      4'd9: row = 40'h0C9292523C;
      default: row = 40'h0;
    endcase
    return row[39-8*col -: 8];
  endfunction

  // Queue the thirty columns that one readout draws.
  function automatic void predict_readout(input logic [ValueWidth-1:0] v,
                                          input logic [2:0] hl);
    int      rest;
    int      place;
    int      digit;
    int      shown;
    bit      leading;
    bit      blank;
    logic [7:0] mask;
    column_t col;
    rest    = v;
    place   = 10000;
    leading = 1'b1;
    shown   = 0;
    for (int pos = 0; pos < DigitCount; pos++) begin
      digit = rest / place;
      rest  = rest - digit * place;
      blank = leading && (pos != DigitCount - 1) && (digit == 0);
      if (!blank) begin
        leading = 1'b0;
        shown++;
      end
      mask = (hl == pos) ? 8'hFF : 8'h00;
      for (int c = 0; c < ColsPerDigit; c++) begin
        col.bits  = ((blank || c >= GlyphCols) ? 8'h00 : font_column(digit[3:0], c)) ^ mask;
        col.last  = 1'b0;
        col.shown = 3'd0;
        expected_columns.push_back(col);
      end
      place = place / 10;
    end
    // Tag the final column with the shown-digit count.
    col = expected_columns.pop_back();
    col.last  = 1'b1;
    col.shown = shown[2:0];
    expected_columns.push_back(col);
  endfunction

  always @(posedge clk) begin
    column_t exp_col;
    if (rst) begin
      expected_columns.delete();
    end else begin
      if (strobe) begin
        if (expected_columns.size() == 0) begin
          $display("%0t: unexpected column: bits %02h last %0b shown %0d", $time,
                   column_bits, last_column, digits_shown);
          error_count++;
        end else begin
          exp_col = expected_columns.pop_front();
          if (column_bits !== exp_col.bits || last_column !== exp_col.last ||
              digits_shown !== exp_col.shown) begin
            $display("%0t: column mismatch: expected bits %02h last %0b shown %0d, got bits %02h last %0b shown %0d",
                     $time, exp_col.bits, exp_col.last, exp_col.shown,
                     column_bits, last_column, digits_shown);
            error_count++;
          end
          checked_count++;
        end
      end
      if (start && !busy) begin
        predict_readout(value, highlight_position);
      end
    end
    pending_count = expected_columns.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench import drgs_pkg::*;;

  localparam logic [2:0] NoHighlight   = 3'd5;
  localparam int         TotalItems    = 410;
  localparam int         WatchdogLimit = 1000;
  localparam int         DrainCycles   = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [ValueWidth-1:0] value = '0;
  logic [2:0]            highlight_position = NoHighlight;
  logic                  busy;
  logic                  strobe;
  logic [7:0]            column_bits;
  logic                  last_column;
  logic [2:0]            digits_shown;

  int error_count;
  int pending_count;
  int checked_count;
  int sent_count = 0;
  int directed_count = 0;
  int highlighted_count = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  decimal_readout_glyph_stream u_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .value              (value),
    .highlight_position (highlight_position),
    .strobe             (strobe),
    .column_bits        (column_bits),
    .last_column        (last_column),
    .digits_shown       (digits_shown)
  );

  readout_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .value              (value),
    .highlight_position (highlight_position),
    .strobe             (strobe),
    .column_bits        (column_bits),
    .last_column        (last_column),
    .digits_shown       (digits_shown),
    .error_count        (error_count),
    .pending_count      (pending_count),
    .checked_count      (checked_count)
  );

  // Count cycles with neither a transaction nor a column.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired with %0d columns outstanding", $time, pending_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hold start until the transaction is taken.
  task automatic send_readout(input logic [ValueWidth-1:0] v, input logic [2:0] hl);
    @(negedge clk);
    start              <= 1'b1;
    value              <= v;
    highlight_position <= hl;
    sent_count++;
    if (hl < NoHighlight) highlighted_count++;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [ValueWidth-1:0] random_value();
    logic [ValueWidth-1:0] v;
    case ($urandom_range(0, 5))
      0: v = ValueWidth'($urandom_range(0, 9));
      1: v = ValueWidth'($urandom_range(10, 999));
      2: v = ValueWidth'($urandom_range(1000, 65535));
      // interior zeros
      3: v = ValueWidth'($urandom_range(1, 6) * 10000 + $urandom_range(0, 9) * 10);
      4: begin
        case ($urandom_range(0, 3))
          0: v = 16'd0;
          1: v = 16'hFFFF;
          2: v = 16'd9999;
          default: v = 16'd10000;
        endcase
      end
      default: v = ValueWidth'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [2:0] random_highlight();
    if ($urandom_range(0, 7) == 0) return 3'($urandom_range(5, 7));
    return 3'($urandom_range(0, 4));
  endfunction

  initial begin
    int burst;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every position, blanked and out-of-range highlights
    send_readout(16'd0, NoHighlight);
    send_readout(16'd0, 3'd4);
    send_readout(16'd0, 3'd0);
    send_readout(16'hFFFF, 3'd7);
    send_readout(16'hFFFF, 3'd0);
    send_readout(16'd1, 3'd6);
    send_readout(16'd9, 3'd3);
    send_readout(16'd10, 3'd3);
    send_readout(16'd100, 3'd2);
    send_readout(16'd1000, 3'd1);
    send_readout(16'd10000, 3'd0);
    send_readout(16'd10001, 3'd2);
    send_readout(16'd60006, 3'd1);
    send_readout(16'd9999, 3'd4);
    send_readout(16'd12345, NoHighlight);
    send_readout(16'd57890, 3'd3);
    pause_sender(25);
    send_readout(16'd5, 3'd1);
    send_readout(16'd42, 3'd0);
    send_readout(16'd50000, 3'd4);
    send_readout(16'd32768, 3'd2);
    send_readout(16'd21845, 3'd6);
    send_readout(16'd43690, 3'd7);
    pause_sender(3);
    directed_count = sent_count;

    while (sent_count < TotalItems) begin
      burst = $urandom_range(1, 12);
      repeat (burst) send_readout(random_value(), random_highlight());
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 40));
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Ran %0d readouts (%0d directed, %0d with a digit highlighted)",
             sent_count, directed_count, highlighted_count);
    $display("Compared %0d display columns against prediction", checked_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
